// ===== rtl/core/l2vn_pkg.sv =====
// shared types, constants and the seed table of the l2 vector normalizer
`timescale 1ns / 1ps
package l2vn_pkg;

  localparam int MAX_DIM      = 64;
  localparam int NEWTON_STEPS = 3;

  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 37;
  localparam int E_MAX   = (SUM_W + 1) / 2;
  localparam int NORM_W  = 2 * E_MAX;
  localparam int E_W     = $clog2(E_MAX + 1);
  localparam int SH_W    = $clog2(E_MAX + 16);
  localparam int F_W     = 31;
  localparam int R_W     = 32;
  localparam int OPB_W   = R_W + 1;
  localparam int P_W     = 64;
  localparam int SCL_W   = 48;
  localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int STEP_W  = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;

  localparam logic [OPB_W-1:0] THREE_Q30 = OPB_W'(64'd3 << 30);
  localparam logic [ELEM_W-1:0] POS_MAX  = 16'h7fff;
  localparam logic [ELEM_W-1:0] NEG_MAX  = 16'h8000;
  localparam logic [SCL_W-1:0]  POS_LIM  = SCL_W'(32767);
  localparam logic [SCL_W-1:0]  NEG_LIM  = SCL_W'(32768);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NORM,
    ST_NT_RR,
    ST_NT_FT,
    ST_NT_H,
    ST_NT_RH,
    ST_NT_UPD,
    ST_EMIT,
    ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_FT,
    MUL_RH,
    MUL_XR
  } mul_sel_e;

  typedef struct packed {
    logic              load;
    logic              norm_init;
    logic              norm_step;
    logic              seed_load;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              h_cap;
    logic              r_upd;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_last;
    logic              clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             zero;
    logic             norm_done;
    logic             pipe_busy;
    logic [CNT_W-1:0] count;
  } dp_status_t;

  function automatic logic [R_W-1:0] seed_r0(input logic [3:0] idx);
    logic [13:0] s;
    unique case (idx)
      4'd0:    s = 14'd8192;
      4'd1:    s = 14'd8192;
      4'd2:    s = 14'd8192;
      4'd3:    s = 14'd8192;
      4'd4:    s = 14'd7724;
      4'd5:    s = 14'd6986;
      4'd6:    s = 14'd6426;
      4'd7:    s = 14'd5983;
      4'd8:    s = 14'd5620;
      4'd9:    s = 14'd5316;
      4'd10:   s = 14'd5056;
      4'd11:   s = 14'd4831;
      4'd12:   s = 14'd4634;
      4'd13:   s = 14'd4459;
      4'd14:   s = 14'd4303;
      default: s = 14'd4162;
    endcase
    return R_W'(s) << 18;
  endfunction

endpackage

// ===== rtl/core/l2vn_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module l2vn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/l2vn_dp.sv =====
// datapath: element buffer, sum of squares, normalizer, newton unit and scaling pipeline
`timescale 1ns / 1ps
module l2vn_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  l2vn_pkg::ctrl_cmd_t              cmd_i,
  input  logic signed [l2vn_pkg::ELEM_W-1:0] element_i,
  output l2vn_pkg::dp_status_t             status_o,
  output logic signed [l2vn_pkg::ELEM_W-1:0] unit_element_o,
  output logic                             final_result_o,
  output logic                             overlength_o,
  output logic                             result_valid_o
);

  logic [l2vn_pkg::CNT_W-1:0]  count_q;
  logic [l2vn_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                        drop_q;
  logic                        full;
  logic signed [31:0]          sq_s;

  logic [l2vn_pkg::NORM_W-1:0] w_q;
  logic [l2vn_pkg::E_W-1:0]    e_q;
  logic [l2vn_pkg::F_W-1:0]    f_val;

  logic [l2vn_pkg::R_W-1:0]    r_q;
  logic [l2vn_pkg::R_W-1:0]    h_q, h_d;
  logic [l2vn_pkg::OPB_W-1:0]  t_val;
  logic [l2vn_pkg::P_W-1:0]    p_q;
  logic [l2vn_pkg::R_W-1:0]    op_a;
  logic [l2vn_pkg::OPB_W-1:0]  op_b;
  logic [64:0]                 prod;

  logic [l2vn_pkg::ELEM_W-1:0] rdata;
  logic [l2vn_pkg::ELEM_W-1:0] mag;
  logic                        s1_valid_q, s1_last_q;
  logic                        s2_valid_q, s2_last_q, s2_neg_q;

  logic [l2vn_pkg::SH_W-1:0]   sh;
  logic [l2vn_pkg::SCL_W-1:0]  rnd, scl_sum, q_val;
  logic [l2vn_pkg::ELEM_W-1:0] sat_d;

  logic [l2vn_pkg::ELEM_W-1:0] unit_q;
  logic                        last_q, over_q, out_valid_q;

  // accumulation
  assign full  = (count_q == l2vn_pkg::CNT_W'(l2vn_pkg::MAX_DIM));
  assign sq_s  = element_i * element_i;
  assign sum_d = sum_q + l2vn_pkg::SUM_W'(unsigned'(sq_s));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (!full) begin
        count_q <= count_q + l2vn_pkg::CNT_W'(1);
        sum_q   <= sum_d;
      end else begin
        drop_q  <= 1'b1;
      end
    end
  end

  l2vn_ram #(
    .WIDTH (l2vn_pkg::ELEM_W),
    .DEPTH (l2vn_pkg::MAX_DIM)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (count_q[l2vn_pkg::ADDR_W-1:0]),
    .wdata_i (element_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  // normalize sum into [0.25, 1), two bits per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_init) begin
      w_q <= l2vn_pkg::NORM_W'(sum_q);
      e_q <= l2vn_pkg::E_W'(l2vn_pkg::E_MAX);
    end else if (cmd_i.norm_step) begin
      w_q <= w_q << 2;
      e_q <= e_q - l2vn_pkg::E_W'(1);
    end
  end

  assign f_val = w_q[l2vn_pkg::NORM_W-1 -: l2vn_pkg::F_W];

  // shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      l2vn_pkg::MUL_RR: begin
        op_a = r_q;
        op_b = {1'b0, r_q};
      end
      l2vn_pkg::MUL_FT: begin
        op_a = {1'b0, f_val};
        op_b = p_q[62:30];
      end
      l2vn_pkg::MUL_RH: begin
        op_a = r_q;
        op_b = {1'b0, h_q};
      end
      default: begin
        op_a = l2vn_pkg::R_W'(mag);
        op_b = {1'b0, r_q};
      end
    endcase
  end

  assign prod  = op_a * op_b;
  assign t_val = p_q[63:31];
  assign h_d   = (t_val >= l2vn_pkg::THREE_Q30) ? '0
                 : l2vn_pkg::R_W'(l2vn_pkg::THREE_Q30 - t_val);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= prod[l2vn_pkg::P_W-1:0];
    end
    if (cmd_i.h_cap) begin
      h_q <= h_d;
    end
    if (cmd_i.seed_load) begin
      r_q <= l2vn_pkg::seed_r0(f_val[l2vn_pkg::F_W-1 -: 4]);
    end else if (cmd_i.r_upd) begin
      r_q <= p_q[62:31];
    end
  end

  // scaling pipeline
  assign mag = rdata[l2vn_pkg::ELEM_W-1] ? (l2vn_pkg::ELEM_W'(0) - rdata) : rdata;

  assign sh      = l2vn_pkg::SH_W'(e_q) + l2vn_pkg::SH_W'(15);
  assign rnd     = l2vn_pkg::SCL_W'(1) << (sh - l2vn_pkg::SH_W'(1));
  assign scl_sum = p_q[l2vn_pkg::SCL_W-1:0] + rnd;
  assign q_val   = scl_sum >> sh;

  always_comb begin
    if (status_o.zero) begin
      sat_d = '0;
    end else if (s2_neg_q) begin
      sat_d = (q_val > l2vn_pkg::NEG_LIM) ? l2vn_pkg::NEG_MAX
              : (l2vn_pkg::ELEM_W'(0) - q_val[l2vn_pkg::ELEM_W-1:0]);
    end else begin
      sat_d = (q_val > l2vn_pkg::POS_LIM) ? l2vn_pkg::POS_MAX
              : q_val[l2vn_pkg::ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.rd_en;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= cmd_i.rd_last;
    s2_last_q <= s1_last_q;
    s2_neg_q  <= rdata[l2vn_pkg::ELEM_W-1];
    if (s2_valid_q) begin
      unit_q <= sat_d;
      last_q <= s2_last_q;
      over_q <= drop_q;
    end
  end

  assign status_o.zero      = (sum_q == '0);
  assign status_o.norm_done = |w_q[l2vn_pkg::NORM_W-1 -: 2];
  assign status_o.pipe_busy = s1_valid_q | s2_valid_q;
  assign status_o.count     = count_q;

  assign unit_element_o = signed'(unit_q);
  assign final_result_o = last_q;
  assign overlength_o   = over_q;
  assign result_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !s1_valid_q && !s2_valid_q)
    else $error("state cleared while results still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && cmd_i.load && !cmd_i.clear) |=> drop_q)
    else $error("element on full buffer not flagged");

endmodule

// ===== rtl/core/l2vn_ctrl.sv =====
// controller: sequences load, normalize, newton iterations and emission
`timescale 1ns / 1ps
module l2vn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 final_element_i,
  input  l2vn_pkg::dp_status_t status_i,
  output l2vn_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  l2vn_pkg::state_e             state_q, state_d;
  logic [l2vn_pkg::STEP_W-1:0]  step_q, step_d;
  logic [l2vn_pkg::CNT_W-1:0]   idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= l2vn_pkg::ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.mul_sel = l2vn_pkg::MUL_XR;
    cmd_o.rd_addr = idx_q[l2vn_pkg::ADDR_W-1:0];
    unique case (state_q)
      l2vn_pkg::ST_IDLE: begin
        cmd_o.load = start_i;
        if (start_i && final_element_i) begin
          state_d = l2vn_pkg::ST_CHECK;
        end
      end
      l2vn_pkg::ST_CHECK: begin
        if (status_i.zero) begin
          state_d = l2vn_pkg::ST_EMIT;
        end else begin
          cmd_o.norm_init = 1'b1;
          state_d         = l2vn_pkg::ST_NORM;
        end
      end
      l2vn_pkg::ST_NORM: begin
        if (status_i.norm_done) begin
          cmd_o.seed_load = 1'b1;
          step_d          = '0;
          state_d         = l2vn_pkg::ST_NT_RR;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      l2vn_pkg::ST_NT_RR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = l2vn_pkg::MUL_RR;
        state_d       = l2vn_pkg::ST_NT_FT;
      end
      l2vn_pkg::ST_NT_FT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = l2vn_pkg::MUL_FT;
        state_d       = l2vn_pkg::ST_NT_H;
      end
      l2vn_pkg::ST_NT_H: begin
        cmd_o.h_cap = 1'b1;
        state_d     = l2vn_pkg::ST_NT_RH;
      end
      l2vn_pkg::ST_NT_RH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = l2vn_pkg::MUL_RH;
        state_d       = l2vn_pkg::ST_NT_UPD;
      end
      l2vn_pkg::ST_NT_UPD: begin
        cmd_o.r_upd = 1'b1;
        if (step_q == l2vn_pkg::STEP_W'(l2vn_pkg::NEWTON_STEPS - 1)) begin
          step_d  = '0;
          state_d = l2vn_pkg::ST_EMIT;
        end else begin
          step_d  = step_q + l2vn_pkg::STEP_W'(1);
          state_d = l2vn_pkg::ST_NT_RR;
        end
      end
      l2vn_pkg::ST_EMIT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_last = (idx_q == status_i.count - l2vn_pkg::CNT_W'(1));
        if (cmd_o.rd_last) begin
          idx_d   = '0;
          state_d = l2vn_pkg::ST_DRAIN;
        end else begin
          idx_d   = idx_q + l2vn_pkg::CNT_W'(1);
        end
      end
      l2vn_pkg::ST_DRAIN: begin
        cmd_o.mul_en = 1'b1;
        if (!status_i.pipe_busy) begin
          cmd_o.clear = 1'b1;
          state_d     = l2vn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = l2vn_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != l2vn_pkg::ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == l2vn_pkg::ST_NORM) |-> !status_i.zero)
    else $error("normalizing a zero sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.rd_last) |=> (state_q == l2vn_pkg::ST_DRAIN))
    else $error("emission did not end after last read");

endmodule

// ===== rtl/core/l2_vector_normalizer.sv =====
// top level of the l2 vector normalizer
//
// an element transfer happens on a clock edge with start_i high and busy_o low;
// element_i and final_element_i are sampled there. elements load one per cycle
// into a 64-deep buffer while the sum of squares accumulates; elements past the
// buffer depth are dropped and overlength_o is set on every result of that vector.
// on the final element busy_o rises; the block normalizes the sum with two-bit
// left shifts, then runs 3 newton steps (rr, ft, h, rh and upd states each) on
// the shared multiplier, then replays the buffer one element per cycle through
// ram read, multiply and round/saturate stages. a zero vector skips the rsqrt.
// the results come one per cycle; busy_o falls in the cycle after the last
// strobe. results are one-cycle strobes that cannot be held off. reset clears
// counters, sum, flags and the state machine; buffer contents are not cleared.
`timescale 1ns / 1ps
module l2_vector_normalizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [l2vn_pkg::ELEM_W-1:0] element_i,
  input  logic                               final_element_i,
  output logic                               result_valid_o,
  output logic signed [l2vn_pkg::ELEM_W-1:0] unit_element_o,
  output logic                               final_result_o,
  output logic                               overlength_o
);

  l2vn_pkg::ctrl_cmd_t  cmd;
  l2vn_pkg::dp_status_t status;

  l2vn_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .final_element_i (final_element_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .busy_o          (busy_o)
  );

  l2vn_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .element_i      (element_i),
    .status_o       (status),
    .unit_element_o (unit_element_o),
    .final_result_o (final_result_o),
    .overlength_o   (overlength_o),
    .result_valid_o (result_valid_o)
  );

endmodule
